@@ rtl/core/mftg_pkg.sv @@
// Shared types and constants for the mains fault trip guard.
package mftg_pkg;

	// Fault codes, shared by the latched fault and the per-reading class
	typedef enum logic [2:0] {
		FLT_NONE     = 3'd0,
		FLT_UNDER_V  = 3'd1,
		FLT_OVER_V   = 3'd2,
		FLT_OVER_I   = 3'd3,
		FLT_OVERLOAD = 3'd4,
		FLT_LOW_PF   = 3'd5,
		FLT_SHORT    = 3'd6
	} fault_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 22;
	localparam int RECOVERY_W  = 22;
	localparam int COUNT_W     = 8;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_VOLTAGE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_VOLTAGE      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_CURRENT      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_POWER        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_POWER_FACTOR = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIP_COUNT_LIMIT = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY_MS      = 3'd6;

	// Reset values of the configuration registers
	localparam logic [11:0]           RST_MIN_VOLTAGE      = 12'd1900;
	localparam logic [11:0]           RST_MAX_VOLTAGE      = 12'd2500;
	localparam logic [16:0]           RST_MAX_CURRENT      = 17'd16000;
	localparam logic [15:0]           RST_MAX_POWER        = 16'd3500;
	localparam logic [9:0]            RST_MIN_POWER_FACTOR = 10'd850;
	localparam logic [COUNT_W-1:0]    RST_TRIP_COUNT_LIMIT = 8'd3;
	localparam logic [RECOVERY_W-1:0] RST_RECOVERY_MS      = 22'd30000;

	// Power factor is only judged above this load
	localparam logic [15:0] PF_MIN_POWER_W = 16'd100;

	typedef struct packed {
		logic        op;
		logic        reading_valid;
		logic [11:0] voltage_dv;
		logic [16:0] current_ma;
		logic [15:0] power_w;
		logic [9:0]  pf_milli;
	} item_t;

	typedef struct packed {
		fault_t active_fault;
		fault_t reading_fault;
		logic   relay_closed;
		logic   alarm_on;
	} result_t;

	typedef struct packed {
		logic [11:0]           min_voltage;
		logic [11:0]           max_voltage;
		logic [16:0]           max_current;
		logic [15:0]           max_power;
		logic [9:0]            min_power_factor;
		logic [COUNT_W-1:0]    trip_count_limit;
		logic [RECOVERY_W-1:0] recovery_ms;
	} cfg_t;

	// What one word asks of the state update
	typedef struct packed {
		logic   tick;
		logic   reading;    // a measurement flagged valid
		fault_t cls;
	} step_t;

endpackage

@@ rtl/core/mftg_classify.sv @@
// Fault classification of one registered word against the thresholds.
module mftg_classify (
	input  mftg_pkg::item_t item,
	input  mftg_pkg::cfg_t  cfg,
	output mftg_pkg::step_t step
);

	logic [18:0]     cur_x2;
	logic [18:0]     lim_x3;
	logic            is_short;
	mftg_pkg::fault_t cls;

	// Short circuit: current*2 > limit*3, exact in 19 bits
	assign cur_x2   = {1'b0, item.current_ma, 1'b0};
	assign lim_x3   = {2'b00, cfg.max_current} + {1'b0, cfg.max_current, 1'b0};
	assign is_short = cur_x2 > lim_x3;

	always_comb begin
		cls = mftg_pkg::FLT_NONE;
		if (!item.op && item.reading_valid) begin
			if (is_short) begin
				cls = mftg_pkg::FLT_SHORT;
			end else if (item.voltage_dv > cfg.max_voltage) begin
				cls = mftg_pkg::FLT_OVER_V;
			end else if (item.voltage_dv < cfg.min_voltage) begin
				cls = mftg_pkg::FLT_UNDER_V;
			end else if (item.current_ma > cfg.max_current) begin
				cls = mftg_pkg::FLT_OVER_I;
			end else if (item.power_w > cfg.max_power) begin
				cls = mftg_pkg::FLT_OVERLOAD;
			end else if (item.pf_milli < cfg.min_power_factor &&
					item.power_w > mftg_pkg::PF_MIN_POWER_W) begin
				cls = mftg_pkg::FLT_LOW_PF;
			end
		end
	end

	assign step.tick    = item.op;
	assign step.reading = !item.op && item.reading_valid;
	assign step.cls     = cls;

endmodule

@@ rtl/core/mftg_trip_state.sv @@
// Trip state: debounce counter, latched fault, relay and cooldown timer.
module mftg_trip_state #(
	parameter int TIMER_BITS = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  mftg_pkg::step_t   step,
	input  mftg_pkg::cfg_t    cfg,
	output mftg_pkg::result_t result
);

	localparam int CMP_W = (TIMER_BITS > mftg_pkg::RECOVERY_W) ?
		TIMER_BITS : mftg_pkg::RECOVERY_W;

	logic                            tripped_q,  tripped_n;
	mftg_pkg::fault_t                latched_q,  latched_n;
	logic [mftg_pkg::COUNT_W-1:0]    count_q,    count_n;
	logic [TIMER_BITS-1:0]           since_q,    since_n;
	logic                            cooled;

	assign cooled = CMP_W'(since_q) > CMP_W'(cfg.recovery_ms);

	always_comb begin
		tripped_n = tripped_q;
		latched_n = latched_q;
		count_n   = count_q;
		since_n   = since_q;
		if (step.tick) begin
			// saturate the cooldown timer
			if (!(&since_q)) begin
				since_n = since_q + 1'b1;
			end
		end else if (step.cls == mftg_pkg::FLT_SHORT) begin
			if (!(tripped_q && latched_q == mftg_pkg::FLT_SHORT)) begin
				tripped_n = 1'b1;
				latched_n = mftg_pkg::FLT_SHORT;
				since_n   = '0;
			end
		end else if (step.cls != mftg_pkg::FLT_NONE) begin
			if (!(&count_q)) begin
				count_n = count_q + 1'b1;
			end
			if (count_n >= cfg.trip_count_limit && !tripped_q) begin
				tripped_n = 1'b1;
				latched_n = step.cls;
				since_n   = '0;
			end
		end else if (step.reading) begin
			// a clean reading; an invalid one falls through and changes nothing
			if (step.cls == mftg_pkg::FLT_NONE && count_q != '0) begin
				count_n = count_q - 1'b1;
			end
			if (tripped_q && latched_q != mftg_pkg::FLT_SHORT && cooled) begin
				tripped_n = 1'b0;
				latched_n = mftg_pkg::FLT_NONE;
				count_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tripped_q <= 1'b0;
			latched_q <= mftg_pkg::FLT_NONE;
			count_q   <= '0;
			since_q   <= '0;
		end else if (advance) begin
			tripped_q <= tripped_n;
			latched_q <= latched_n;
			count_q   <= count_n;
			since_q   <= since_n;
		end
	end

	assign result.active_fault  = latched_n;
	assign result.reading_fault = step.cls;
	assign result.relay_closed  = !tripped_n;
	assign result.alarm_on      = tripped_n;

endmodule

@@ rtl/core/mains_fault_trip_guard_top.sv @@
// Top level of the mains fault trip guard: ports, configuration and pipeline.
// Each word on the item channel is either a measurement reading or a one
// millisecond tick, and each gives exactly one result word. Words flow at one
// per clock while the result side keeps up: a word is taken into the input
// register, classified and applied to the trip state, and its result is
// registered in the result register; a stalled result only holds up the
// input once the input register is full too.
// The rate is set by the single update path from the input register through
// the classifier and the trip state into the result register. A reading whose
// current exceeds one and a half times the current limit trips the relay at
// once as a short circuit, which never recovers on its own; other faults
// (over/under voltage, overcurrent, overload, low power factor above 100 W)
// are debounced by a saturating up/down counter. A clean reading after the
// cooldown (counted in ticks) closes the relay again. Invalid readings change
// nothing. Configuration registers are written through the cfg channel,
// which is always ready, and should only be written while the block is idle;
// indexes beyond the register list are dropped. TIMER_BITS sets the width of
// the cooldown timer, which saturates at its all-ones value.
module mains_fault_trip_guard_top #(
	parameter int TIMER_BITS = 22
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  mftg_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output mftg_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mftg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mftg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mftg_pkg::cfg_t    cfg_q;
	mftg_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              advance;
	mftg_pkg::step_t   step;
	mftg_pkg::result_t result_n;
	mftg_pkg::result_t result_q;
	logic              result_valid_q;

	// Configuration: always ready, drop writes to unknown indexes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_voltage      <= mftg_pkg::RST_MIN_VOLTAGE;
			cfg_q.max_voltage      <= mftg_pkg::RST_MAX_VOLTAGE;
			cfg_q.max_current      <= mftg_pkg::RST_MAX_CURRENT;
			cfg_q.max_power        <= mftg_pkg::RST_MAX_POWER;
			cfg_q.min_power_factor <= mftg_pkg::RST_MIN_POWER_FACTOR;
			cfg_q.trip_count_limit <= mftg_pkg::RST_TRIP_COUNT_LIMIT;
			cfg_q.recovery_ms      <= mftg_pkg::RST_RECOVERY_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mftg_pkg::REG_MIN_VOLTAGE:      cfg_q.min_voltage      <= cfg_data[11:0];
				mftg_pkg::REG_MAX_VOLTAGE:      cfg_q.max_voltage      <= cfg_data[11:0];
				mftg_pkg::REG_MAX_CURRENT:      cfg_q.max_current      <= cfg_data[16:0];
				mftg_pkg::REG_MAX_POWER:        cfg_q.max_power        <= cfg_data[15:0];
				mftg_pkg::REG_MIN_POWER_FACTOR: cfg_q.min_power_factor <= cfg_data[9:0];
				mftg_pkg::REG_TRIP_COUNT_LIMIT: cfg_q.trip_count_limit <= cfg_data[7:0];
				mftg_pkg::REG_RECOVERY_MS:      cfg_q.recovery_ms      <= cfg_data[21:0];
				default: begin
				end
			endcase
		end
	end

	// Advance the input word into the result register whenever that register
	// is empty or being emptied this cycle
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload: hold while stalled, no reset needed
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	mftg_classify u_classify (
		.item (item_s1),
		.cfg  (cfg_q),
		.step (step)
	);

	mftg_trip_state #(
		.TIMER_BITS (TIMER_BITS)
	) u_trip_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.step    (step),
		.cfg     (cfg_q),
		.result  (result_n)
	);

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// An accepted word always reaches the input register
	a_item_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> valid_s1)
		else $error("accepted word did not reach the input register");

	// Relay and alarm are always opposite
	a_relay_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.relay_closed != result.alarm_on))
		else $error("relay and alarm disagree");

	// A tripped relay always carries a latched fault
	a_trip_has_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.alarm_on) |-> (result.active_fault != mftg_pkg::FLT_NONE))
		else $error("tripped without a latched fault");

	// A short circuit reading always leaves the relay open on a short
	a_short_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.reading_fault == mftg_pkg::FLT_SHORT) |->
			(result.alarm_on && result.active_fault == mftg_pkg::FLT_SHORT))
		else $error("short circuit did not latch");
`endif

endmodule

@@ test/tb_mains_fault_trip_guard_top.sv @@
// Self-checking testbench for the mains fault trip guard top level.
`timescale 1ns / 1ps

module tb_mains_fault_trip_guard_top;
	import mftg_pkg::*;

	localparam int TIMER_W    = 22;
	localparam int CYCLE_CAP  = 200000;
	// The register map stops at six; index seven must be dropped by the block
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	// Predicts the guard's trip state and holds the result words still owed by the block
	class trip_tracker;
		cfg_t               regs;
		logic               tripped;
		fault_t             latched;
		logic [COUNT_W-1:0] fault_count;
		logic [TIMER_W-1:0] since_trip_ms;
		result_t            due_results[$];
		int                 mismatches;
		int                 words, ticks, ignored, results, trips, recoveries, shorts;

		function new();
			regs = '{RST_MIN_VOLTAGE, RST_MAX_VOLTAGE, RST_MAX_CURRENT, RST_MAX_POWER,
				RST_MIN_POWER_FACTOR, RST_TRIP_COUNT_LIMIT, RST_RECOVERY_MS};
			tripped       = 1'b0;
			latched       = FLT_NONE;
			fault_count   = '0;
			since_trip_ms = '0;
			mismatches    = 0;
			words         = 0;
			ticks         = 0;
			ignored       = 0;
			results       = 0;
			trips         = 0;
			recoveries    = 0;
			shorts        = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_MIN_VOLTAGE:      regs.min_voltage      = data[11:0];
				REG_MAX_VOLTAGE:      regs.max_voltage      = data[11:0];
				REG_MAX_CURRENT:      regs.max_current      = data[16:0];
				REG_MAX_POWER:        regs.max_power        = data[15:0];
				REG_MIN_POWER_FACTOR: regs.min_power_factor = data[9:0];
				REG_TRIP_COUNT_LIMIT: regs.trip_count_limit = data[COUNT_W-1:0];
				REG_RECOVERY_MS:      regs.recovery_ms      = data[RECOVERY_W-1:0];
				default: ;
			endcase
		endfunction

		function void open_path(fault_t why);
			if (tripped && latched == why)
				return;
			tripped       = 1'b1;
			latched       = why;
			since_trip_ms = '0;
			trips++;
			if (why == FLT_SHORT)
				shorts++;
		endfunction

		function void note_item(item_t w);
			fault_t          cls;
			result_t         want;
			longint unsigned twice_ma;
			longint unsigned limit_x3;
			cls      = FLT_NONE;
			twice_ma = 64'(w.current_ma) * 2;
			limit_x3 = 64'(regs.max_current) * 3;
			words++;
			if (w.op) begin
				ticks++;
				if (since_trip_ms != '1)
					since_trip_ms++;
			end else if (!w.reading_valid) begin
				ignored++;
			end else if (twice_ma > limit_x3) begin
				cls = FLT_SHORT;
				open_path(FLT_SHORT);
			end else begin
				if (w.voltage_dv > regs.max_voltage)
					cls = FLT_OVER_V;
				else if (w.voltage_dv < regs.min_voltage)
					cls = FLT_UNDER_V;
				else if (w.current_ma > regs.max_current)
					cls = FLT_OVER_I;
				else if (w.power_w > regs.max_power)
					cls = FLT_OVERLOAD;
				else if (w.pf_milli < regs.min_power_factor && w.power_w > PF_MIN_POWER_W)
					cls = FLT_LOW_PF;
				if (cls != FLT_NONE) begin
					if (fault_count != '1)
						fault_count++;
					if (fault_count >= regs.trip_count_limit && !tripped)
						open_path(cls);
				end else begin
					if (fault_count != '0)
						fault_count--;
					if (tripped && latched != FLT_SHORT && since_trip_ms > regs.recovery_ms) begin
						tripped     = 1'b0;
						latched     = FLT_NONE;
						fault_count = '0;
						recoveries++;
					end
				end
			end
			want.active_fault  = latched;
			want.reading_fault = cls;
			want.relay_closed  = !tripped;
			want.alarm_on      = tripped;
			due_results.push_back(want);
		endfunction

		function void complain(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at result %0d: %s", results, msg);
		endfunction

		function void compare(string field, logic [2:0] want, logic [2:0] got);
			if (got !== want)
				complain($sformatf("%s expected %0d, got %0d", field, want, got));
		endfunction

		function void check_result(result_t got);
			result_t want;
			results++;
			if (due_results.size() == 0) begin
				complain($sformatf("unexpected word, active %0d class %0d relay %0b alarm %0b",
					got.active_fault, got.reading_fault, got.relay_closed, got.alarm_on));
				return;
			end
			want = due_results.pop_front();
			compare("active_fault", want.active_fault, got.active_fault);
			compare("reading_fault", want.reading_fault, got.reading_fault);
			compare("relay_closed", {2'b0, want.relay_closed}, {2'b0, got.relay_closed});
			compare("alarm_on", {2'b0, want.alarm_on}, {2'b0, got.alarm_on});
		endfunction
	endclass

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_ready;
	item_t                  item         = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	trip_tracker tracker;
	cfg_t        knob;        // settings the stimulus is shaped around
	bit          idle_on;     // random gaps and stalls allowed
	int          stall_left;
	int          cycles;

	mains_fault_trip_guard_top #(
		.TIMER_BITS(TIMER_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watch every handshake at the clock edge; all inputs change by nonblocking
	// assignment, so the values read here are the ones the block sampled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.set_reg(cfg_index, cfg_data);
			if (item_valid && item_ready)
				tracker.note_item(item);
			if (result_valid && result_ready)
				tracker.check_result(result);
		end
	end

	// Receiver back-pressure: stall in bursts of random length while idling is on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			stall_left   <= $urandom_range(0, 9);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Give up on a hung block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d words still owed", cycles,
				tracker.due_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int unsigned pick(int unsigned lo, int unsigned hi);
		return (lo >= hi) ? lo : $urandom_range(hi, lo);
	endfunction

	function automatic item_t reading(int unsigned v, int unsigned i, int unsigned p,
			int unsigned pf);
		return {1'b0, 1'b1, v[11:0], i[16:0], p[15:0], pf[9:0]};
	endfunction

	// A tick, or a reading with a random valid flag, with every payload bit random
	function automatic item_t noise(logic op);
		return {op, 1'($urandom), 12'($urandom), 17'($urandom), 16'($urandom), 10'($urandom)};
	endfunction

	// Highest current that still stays clear of the short-circuit test
	function automatic int unsigned short_free_ma();
		int unsigned c;
		c = (3 * int'(knob.max_current)) / 2;
		return (c > 131071) ? 131071 : c;
	endfunction

	function automatic item_t clean_reading();
		item_t w;
		w = reading(pick(knob.min_voltage, knob.max_voltage), pick(0, knob.max_current),
			pick(0, knob.max_power), pick(knob.min_power_factor, 1023));
		// Pin one field on its limit now and then
		case ($urandom_range(0, 7))
			0: w.voltage_dv = $urandom_range(0, 1) ? knob.max_voltage : knob.min_voltage;
			1: w.current_ma = knob.max_current;
			2: w.power_w    = knob.max_power;
			3: w.pf_milli   = knob.min_power_factor;
			4: begin
				// Light load: the power factor is not judged at all
				w.power_w  = 16'(pick(0, (knob.max_power < 100) ? knob.max_power : 100));
				w.pf_milli = 10'($urandom);
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic item_t faulty_reading();
		item_t       w;
		int unsigned cap;
		int unsigned max_v, min_v, max_i, max_p, min_pf;
		bit          near;
		w      = clean_reading();
		cap    = short_free_ma();
		max_v  = knob.max_voltage;
		min_v  = knob.min_voltage;
		max_i  = knob.max_current;
		max_p  = knob.max_power;
		min_pf = knob.min_power_factor;
		near   = ($urandom_range(0, 2) == 0);
		case ($urandom_range(0, 4))
			0: if (max_v < 4095)
				w.voltage_dv = 12'(pick(max_v + 1, near ? max_v + 1 : 4095));
			1: if (min_v > 0)
				w.voltage_dv = 12'(pick(near ? min_v - 1 : 0, min_v - 1));
			2: if (max_i < cap)
				w.current_ma = 17'(pick(max_i + 1, near ? max_i + 1 : cap));
			3: if (max_p < 65535)
				w.power_w = 16'(pick(max_p + 1, near ? max_p + 1 : 65535));
			default: if (min_pf > 0) begin
				w.power_w  = 16'(pick(near ? 101 : 102, 65535));
				w.pf_milli = 10'(pick(near ? min_pf - 1 : 0, min_pf - 1));
			end
		endcase
		return w;
	endfunction

	// Mostly well-formed readings, with ticks and ignored readings mixed in.
	// Shorts latch for good, so they only appear when asked for.
	function automatic item_t random_item(bit allow_short);
		item_t       w;
		int unsigned r;
		int unsigned cap;
		r   = $urandom_range(0, 99);
		cap = short_free_ma();
		if (r < 20) begin
			w = noise(1'b1);
		end else if (r < 30) begin
			w               = noise(1'b0);
			w.reading_valid = 1'b0;
		end else if (r < 65) begin
			w = clean_reading();
		end else begin
			w = faulty_reading();
		end
		if (allow_short && r >= 30 && r % 5 == 0 && cap < 131071)
			w.current_ma = 17'(pick(cap + 1, 131071));
		return w;
	endfunction

	// Present one word and hold it until taken; valid stays high on return
	task automatic send_item(item_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// Drop valid and hold off until every owed result word has come back
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (tracker.due_results.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_index <= index;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write the whole register set; the caller drops cfg_valid afterwards
	task automatic apply_settings(cfg_t s);
		write_reg(REG_MIN_VOLTAGE, CFG_DATA_W'(s.min_voltage));
		write_reg(REG_MAX_VOLTAGE, CFG_DATA_W'(s.max_voltage));
		write_reg(REG_MAX_CURRENT, CFG_DATA_W'(s.max_current));
		write_reg(REG_MAX_POWER, CFG_DATA_W'(s.max_power));
		write_reg(REG_MIN_POWER_FACTOR, CFG_DATA_W'(s.min_power_factor));
		write_reg(REG_TRIP_COUNT_LIMIT, CFG_DATA_W'(s.trip_count_limit));
		write_reg(REG_RECOVERY_MS, CFG_DATA_W'(s.recovery_ms));
		knob = s;
	endtask

	initial begin
		bit ok;
		tracker    = new();
		knob       = tracker.regs;
		idle_on    = 1'b1;
		stall_left = 0;
		cycles     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, directed: every fault class but the short circuit, the limits
		// on both sides, priority between classes, and a debounced trip that cannot yet recover.
		send_item(reading(2300, 5000, 1000, 950));
		send_item({1'b0, 1'b0, 12'hFFF, 17'h1FFFF, 16'hFFFF, 10'h3FF});
		send_item({1'b1, 1'b1, 12'hFFF, 17'h1FFFF, 16'hFFFF, 10'h3FF});
		send_item(reading(2501, 5000, 1000, 950));
		send_item(reading(2500, 16000, 3500, 850));
		send_item(reading(1899, 5000, 1000, 950));
		send_item(reading(1900, 5000, 1000, 950));
		send_item(reading(0, 0, 0, 0));
		send_item(reading(2300, 16001, 1000, 950));
		send_item(reading(2300, 5000, 1000, 950));
		send_item(reading(2300, 24000, 1000, 950));     // at the edge of a short, still ordinary
		send_item(reading(2300, 5000, 1000, 950));
		send_item(reading(2300, 5000, 3501, 950));
		send_item(reading(2300, 5000, 1000, 950));
		send_item(reading(2300, 5000, 101, 849));
		send_item(reading(2300, 5000, 100, 0));         // light load, power factor ignored
		send_item(reading(4095, 20000, 65535, 0));      // overvoltage wins over the rest
		send_item(reading(0, 20000, 65535, 0));         // undervoltage wins, trips on the count
		send_item(reading(2600, 5000, 1000, 950));      // already open, no re-latch
		send_item(reading(2300, 5000, 1000, 950));
		send_item(noise(1'b1));
		send_item(noise(1'b1));
		send_item(reading(2300, 5000, 1000, 950));
		for (int n = 0; n < 80; n++)
			send_item(random_item(1'b0));
		drain();

		// Trip on the first fault, recover once more than five ticks have passed
		apply_settings('{12'd1000, 12'd3000, 17'd5000, 16'd2000, 10'd500, 8'd1, 22'd5});
		cfg_valid <= 1'b0;
		for (int n = 0; n < 100; n++)
			send_item(random_item(1'b0));
		drain();

		// Every register at zero, no idling: a zero limit trips at once
		idle_on = 1'b0;
		apply_settings('0);
		cfg_valid <= 1'b0;
		for (int n = 0; n < 40; n++)
			send_item(random_item(1'b0));
		// Close the path again before the next settings take away recovery
		send_item(noise(1'b1));
		send_item(reading(0, 0, 0, 0));
		drain();

		// Every register at its top: the count must saturate before a trip,
		// and an all-ones cooldown never expires
		idle_on = 1'b1;
		apply_settings('{12'hFFF, 12'hFFF, 17'h1FFFF, 16'hFFFF, 10'h3FF, 8'hFF, 22'h3FFFFF});
		cfg_valid <= 1'b0;
		for (int n = 0; n < 260; n++)
			send_item(faulty_reading());
		for (int n = 0; n < 40; n++)
			send_item(random_item(1'b0));
		drain();

		// Mid-range settings, plus a write with stray upper bits and one to an
		// index beyond the map; pause halfway until the block has caught up
		apply_settings('{12'd1500, 12'd2600, 17'd12000, 16'd3000, 10'd700, 8'd4, 22'd8});
		write_reg(REG_MIN_VOLTAGE, {10'h2D5, 12'd1500});
		write_reg(REG_UNUSED, '1);
		cfg_valid <= 1'b0;
		for (int n = 0; n < 100; n++) begin
			if (n == 50)
				drain();
			send_item(random_item(1'b0));
		end
		drain();

		// Last part, no idling: short circuits latch and never recover
		idle_on = 1'b0;
		apply_settings('{RST_MIN_VOLTAGE, RST_MAX_VOLTAGE, RST_MAX_CURRENT, RST_MAX_POWER,
			RST_MIN_POWER_FACTOR, RST_TRIP_COUNT_LIMIT, 22'd2});
		cfg_valid <= 1'b0;
		repeat (3) send_item(noise(1'b1));
		send_item(reading(2300, 5000, 1000, 950));      // closes the path if still open
		send_item(reading(2501, 5000, 1000, 950));
		send_item(reading(2300, 24001, 1000, 950));     // just over the short-circuit line
		send_item(reading(2300, 131071, 65535, 0));
		send_item(reading(2600, 5000, 1000, 950));
		repeat (3) send_item(noise(1'b1));
		send_item(reading(2300, 5000, 1000, 950));
		drain();
		write_reg(REG_RECOVERY_MS, 22'd4000000);
		cfg_valid <= 1'b0;
		knob.recovery_ms = 22'd4000000;
		send_item(noise(1'b1));
		send_item(reading(2300, 5000, 1000, 950));
		for (int n = 0; n < 20; n++)
			send_item(random_item(1'b1));
		drain();

		// Let any stray result word show itself
		repeat (10) @(posedge clk);

		$display("Covered %0d words: %0d ticks, %0d ignored readings, %0d result words.",
			tracker.words, tracker.ticks, tracker.ignored, tracker.results);
		$display("Saw %0d trips (%0d short circuit) and %0d recoveries; %0d mismatches.",
			tracker.trips, tracker.shorts, tracker.recoveries, tracker.mismatches);
		ok = (tracker.mismatches == 0) && (tracker.due_results.size() == 0);
		if (ok)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
